FILE: rtl/core/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Assert that an implication holds at each rising edge outside reset
`define ASSERT_IMP(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("assertion failed");
// Assert a property that also holds during reset
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`endif

FILE: rtl/core/edfs_pkg.sv
package edfs_pkg;
  localparam int MAX_TASKS_DEF = 8;
  localparam logic [31:0] NO_DEADLINE = 32'hFFFF_FFFF;
  localparam logic [31:0] DEADLINE_MAX = 32'hFFFF_FFFE;
  localparam logic [15:0] MISS_MAX = 16'hFFFF;

  typedef enum logic [2:0] {
    CMD_CREATE  = 3'd0,
    CMD_TICK    = 3'd1,
    CMD_DELAY   = 3'd2,
    CMD_TERM    = 3'd3,
    CMD_BLOCK   = 3'd4,
    CMD_RELEASE = 3'd5,
    CMD_SETDL   = 3'd6,
    CMD_BAD     = 3'd7
  } cmd_t;

  typedef enum logic [2:0] {
    STS_OK      = 3'd0,
    STS_FULL    = 3'd1,
    STS_NONE    = 3'd2,
    STS_ALLDEAD = 3'd3,
    STS_IGNORED = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    RS_READY = 2'd0,
    RS_RUN   = 2'd1,
    RS_BLOCK = 2'd2,
    RS_DEAD  = 2'd3
  } run_state_t;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    sat_add = (s > {1'b0, DEADLINE_MAX}) ? DEADLINE_MAX : s[31:0];
  endfunction
endpackage

FILE: rtl/core/edf_priority_task_scheduler_top.sv
// From the accepting edge, every command passes through S_EXEC and S_EMIT before out_tvalid;
// release first walks the table once in S_REL.
// Tick walks the table with one shared comparator in S_SLEEP, S_MISS (EDF only) and S_PICK,
// then settles the choice in S_COUNT.
// Throughput: one command at a time; in_tready rises in the cycle after out_tvalid.
// Reset (rst_n low, synchronous): empty table, no running task, policy strict priority.
module edf_priority_task_scheduler_top #(
  parameter int MAX_TASKS = edfs_pkg::MAX_TASKS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic         cfg_wdata,      // policy
  input  logic         in_tvalid,
  output logic         in_tready,
  // command[2:0], task_priority[10:3], now_ms[42:11], deadline_offset[74:43],
  // renew_period[90:75], delay_ticks[106:91], owner_task[109:107],
  // absolute_deadline[141:110], zeros[143:142]
  input  logic [143:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // status[2:0], task_id[5:3], missed_count[21:6], zeros[23:22]
  output logic [23:0]  out_tdata
);
  localparam int IW = $clog2(MAX_TASKS);
  localparam int CW = $clog2(MAX_TASKS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_REL, S_SLEEP, S_MISS, S_PICK, S_COUNT, S_EMIT, S_OUT
  } state_t;

  state_t state_r;
  edfs_pkg::run_state_t rs_r [MAX_TASKS];
  logic [7:0]  cur_r [MAX_TASKS];
  logic [7:0]  base_r [MAX_TASKS];
  logic [15:0] sleep_r [MAX_TASKS];
  logic        wm_r [MAX_TASKS];
  logic [31:0] dl_r [MAX_TASKS];
  logic [15:0] per_r [MAX_TASKS];
  logic [15:0] miss_r [MAX_TASKS];
  logic [CW-1:0] created_r;
  logic [CW-1:0] running_r;
  logic        policy_r;

  logic [2:0]  cmd_r;
  logic [7:0]  prio_r;
  logic [31:0] now_r, offs_r, absd_r;
  logic [15:0] pin_r, dly_r;
  logic [2:0]  own_r;
  logic [CW-1:0] idx_r;
  logic [CW-1:0] best_r;
  logic [31:0] bdl_r;
  logic [8:0]  bpr_r;
  logic        act_r;
  logic [2:0]  sts_r;
  logic [CW-1:0] rid_r;
  logic [23:0] out_r;
  logic        ov_r;

  logic [IW-1:0] ix, me;
  logic          have_run, iv;
  logic [IW-1:0] own_ix;
  logic          own_ok;
  assign ix       = idx_r[IW-1:0];
  assign me       = running_r[IW-1:0];
  assign iv       = idx_r < created_r;
  assign own_ix   = IW'(own_r);
  assign own_ok   = 32'(own_r) < 32'(created_r);
  assign have_run = (running_r < created_r) && (running_r < CW'(MAX_TASKS)) &&
                    (rs_r[me] == edfs_pkg::RS_RUN);

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = ov_r;
  assign out_tdata  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      created_r <= '0;
      running_r <= CW'(MAX_TASKS);
      policy_r  <= 1'b0;
      ov_r      <= 1'b0;
      for (int i = 0; i < MAX_TASKS; i++) begin
        rs_r[i]    <= edfs_pkg::RS_READY;
        cur_r[i]   <= '0;
        base_r[i]  <= '0;
        sleep_r[i] <= '0;
        wm_r[i]    <= 1'b0;
        miss_r[i]  <= '0;
      end
    end else begin
      if (cfg_we) policy_r <= cfg_wdata;
      if (ov_r && out_tready) ov_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            cmd_r  <= in_tdata[2:0];
            prio_r <= in_tdata[10:3];
            now_r  <= in_tdata[42:11];
            offs_r <= in_tdata[74:43];
            pin_r  <= in_tdata[90:75];
            dly_r  <= in_tdata[106:91];
            own_r  <= in_tdata[109:107];
            absd_r <= in_tdata[141:110];
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          sts_r   <= edfs_pkg::STS_OK;
          rid_r   <= running_r;
          state_r <= S_EMIT;
          idx_r   <= '0;
          unique case (edfs_pkg::cmd_t'(cmd_r))
            edfs_pkg::CMD_CREATE: begin
              if (created_r >= CW'(MAX_TASKS)) begin
                sts_r <= edfs_pkg::STS_FULL;
              end else begin
                rs_r[created_r[IW-1:0]]    <= edfs_pkg::RS_READY;
                cur_r[created_r[IW-1:0]]   <= prio_r;
                base_r[created_r[IW-1:0]]  <= prio_r;
                sleep_r[created_r[IW-1:0]] <= '0;
                wm_r[created_r[IW-1:0]]    <= 1'b0;
                dl_r[created_r[IW-1:0]]    <= (offs_r == edfs_pkg::NO_DEADLINE) ?
                    edfs_pkg::NO_DEADLINE : edfs_pkg::sat_add(now_r, offs_r);
                per_r[created_r[IW-1:0]]   <= pin_r;
                miss_r[created_r[IW-1:0]]  <= '0;
                rid_r     <= created_r;
                created_r <= created_r + 1'b1;
              end
            end
            edfs_pkg::CMD_TICK: begin
              if (have_run) rs_r[me] <= edfs_pkg::RS_READY;
              state_r <= S_SLEEP;
            end
            edfs_pkg::CMD_DELAY: begin
              if (!have_run || dly_r == '0) sts_r <= edfs_pkg::STS_IGNORED;
              else begin
                sleep_r[me] <= dly_r;
                rs_r[me]    <= edfs_pkg::RS_BLOCK;
              end
            end
            edfs_pkg::CMD_TERM: begin
              if (!have_run) sts_r <= edfs_pkg::STS_IGNORED;
              else rs_r[me] <= edfs_pkg::RS_DEAD;
            end
            edfs_pkg::CMD_BLOCK: begin
              if (!have_run || !own_ok) sts_r <= edfs_pkg::STS_IGNORED;
              else begin
                if (!policy_r) begin
                  if (cur_r[me] > cur_r[own_ix]) cur_r[own_ix] <= cur_r[me];
                end else begin
                  if (dl_r[me] < dl_r[own_ix]) dl_r[own_ix] <= dl_r[me];
                end
                rs_r[me]    <= edfs_pkg::RS_BLOCK;
                wm_r[me]    <= 1'b1;
                sleep_r[me] <= '0;
              end
            end
            edfs_pkg::CMD_RELEASE: begin
              if (!have_run) sts_r <= edfs_pkg::STS_IGNORED;
              else begin
                cur_r[me] <= base_r[me];
                state_r   <= S_REL;
              end
            end
            edfs_pkg::CMD_SETDL: begin
              if (!have_run) sts_r <= edfs_pkg::STS_IGNORED;
              else dl_r[me] <= absd_r;
            end
            default: sts_r <= edfs_pkg::STS_IGNORED;
          endcase
        end
        S_REL: begin
          if (idx_r == CW'(MAX_TASKS)) begin
            rs_r[me] <= edfs_pkg::RS_READY;
            state_r  <= S_EMIT;
          end else begin
            if (iv && rs_r[ix] == edfs_pkg::RS_BLOCK && wm_r[ix]) begin
              rs_r[ix] <= edfs_pkg::RS_READY;
              wm_r[ix] <= 1'b0;
            end
            idx_r <= idx_r + 1'b1;
          end
        end
        S_SLEEP: begin
          if (idx_r == CW'(MAX_TASKS)) begin
            idx_r   <= '0;
            best_r  <= CW'(MAX_TASKS);
            bdl_r   <= edfs_pkg::NO_DEADLINE;
            // bpr_r holds priority + 1 so that any ready task beats the empty start
            bpr_r   <= '0;
            act_r   <= 1'b0;
            state_r <= policy_r ? S_MISS : S_PICK;
          end else begin
            if (iv && rs_r[ix] == edfs_pkg::RS_BLOCK && sleep_r[ix] != '0) begin
              sleep_r[ix] <= sleep_r[ix] - 1'b1;
              if (sleep_r[ix] == 16'd1) rs_r[ix] <= edfs_pkg::RS_READY;
            end
            idx_r <= idx_r + 1'b1;
          end
        end
        S_MISS: begin
          if (idx_r == CW'(MAX_TASKS)) begin
            idx_r   <= '0;
            state_r <= S_PICK;
          end else begin
            if (iv && rs_r[ix] != edfs_pkg::RS_DEAD && dl_r[ix] != edfs_pkg::NO_DEADLINE &&
                now_r > dl_r[ix]) begin
              if (miss_r[ix] != edfs_pkg::MISS_MAX) miss_r[ix] <= miss_r[ix] + 1'b1;
              if (per_r[ix] != '0) dl_r[ix] <= edfs_pkg::sat_add(dl_r[ix], {16'd0, per_r[ix]});
            end
            idx_r <= idx_r + 1'b1;
          end
        end
        S_PICK: begin
          if (idx_r == CW'(MAX_TASKS)) begin
            state_r <= S_COUNT;
          end else begin
            if (iv && (rs_r[ix] == edfs_pkg::RS_READY || rs_r[ix] == edfs_pkg::RS_RUN)) begin
              if (policy_r) begin
                if (dl_r[ix] < bdl_r) begin
                  bdl_r  <= dl_r[ix];
                  best_r <= idx_r;
                end
              end else if ({1'b0, cur_r[ix]} + 9'd1 > bpr_r) begin
                bpr_r  <= {1'b0, cur_r[ix]} + 9'd1;
                best_r <= idx_r;
              end
            end
            if (iv && rs_r[ix] != edfs_pkg::RS_DEAD) act_r <= 1'b1;
            idx_r <= idx_r + 1'b1;
          end
        end
        S_COUNT: begin
          if (!act_r) begin
            running_r <= CW'(MAX_TASKS);
            sts_r     <= edfs_pkg::STS_ALLDEAD;
          end else if (best_r >= CW'(MAX_TASKS)) begin
            running_r <= CW'(MAX_TASKS);
            sts_r     <= edfs_pkg::STS_NONE;
          end else begin
            running_r <= best_r;
            rs_r[best_r[IW-1:0]] <= edfs_pkg::RS_RUN;
            sts_r     <= edfs_pkg::STS_OK;
          end
          rid_r   <= best_r;
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          if (!ov_r) begin
            if (sts_r == edfs_pkg::STS_OK && rid_r < CW'(MAX_TASKS)) begin
              out_r <= {2'b00,
                        (cmd_r == edfs_pkg::CMD_CREATE) ? 16'd0 : miss_r[rid_r[IW-1:0]],
                        3'(rid_r), sts_r};
            end else begin
              out_r <= {21'd0, sts_r};
            end
            ov_r    <= 1'b1;
            state_r <= S_OUT;
          end
        end
        S_OUT: state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: rtl/core/edfs_checker.sv
`include "assert_macros.svh"
module edfs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);
  logic err_word;
  assign err_word = out_tvalid && (out_tdata[2:0] != edfs_pkg::STS_OK);

  `ASSERT_IMP(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
  `ASSERT_IMP(a_status_range, clk, rst_n, out_tvalid |-> out_tdata[2:0] <= edfs_pkg::STS_IGNORED)
  `ASSERT_IMP(a_zero_on_err, clk, rst_n, err_word |-> out_tdata[21:3] == '0)
  `ASSERT_IMP(a_busy_after_accept, clk, rst_n, in_tvalid && in_tready |=> !in_tready)
endmodule

bind edf_priority_task_scheduler_top edfs_checker u_edfs_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);
